// ===== hdl/dvrt_pkg.sv =====
// shared types, constants and codes for the distance-vector route table
package dvrt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int NODE_BITS   = 8;
	localparam int TIME_BITS   = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] METRIC_MAX = 4'd15;

	// command codes
	localparam logic [2:0] CMD_FORWARD = 3'd0;
	localparam logic [2:0] CMD_UPDATE  = 3'd1;
	localparam logic [2:0] CMD_TICK    = 3'd2;
	localparam logic [2:0] CMD_PURGE   = 3'd3;
	localparam logic [2:0] CMD_EMIT    = 3'd4;

	// result kinds
	localparam logic [2:0] KIND_FORWARD = 3'd0;
	localparam logic [2:0] KIND_UPDATE  = 3'd1;
	localparam logic [2:0] KIND_TICK    = 3'd2;
	localparam logic [2:0] KIND_PURGE   = 3'd3;
	localparam logic [2:0] KIND_VECTOR  = 3'd4;

	// actions
	localparam logic [2:0] ACT_FORWARDED = 3'd0;
	localparam logic [2:0] ACT_NO_ROUTE  = 3'd1;
	localparam logic [2:0] ACT_EXPIRED   = 3'd2;
	localparam logic [2:0] ACT_LOCAL     = 3'd3;
	localparam logic [2:0] ACT_CHANGED   = 3'd4;
	localparam logic [2:0] ACT_ADDED     = 3'd5;
	localparam logic [2:0] ACT_IGNORED   = 3'd6;
	localparam logic [2:0] ACT_FULL      = 3'd7;

	// configuration register indexes
	localparam logic [1:0] REG_ROUTER_ID = 2'd0;
	localparam logic [1:0] REG_AGE_LIMIT = 2'd1;
	localparam logic [1:0] REG_INFINITY  = 2'd2;

	typedef struct packed {
		logic [2:0]           command;
		logic [NODE_BITS-1:0] dest_id;
		logic [3:0]           metric;
		logic [NODE_BITS-1:0] neighbor_id;
		logic [7:0]           ttl;
		logic                 end_of_vector;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [2:0]       action;
		logic [7:0]       next_hop;
		logic [7:0]       ttl_left;
		logic [7:0]       out_dest;
		logic [3:0]       out_metric;
		logic [CNT_W-1:0] table_entries;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] dest;
		logic [NODE_BITS-1:0] next_hop;
		logic [3:0]           metric;
		logic [TIME_BITS-1:0] stamp;
	} route_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

// ===== hdl/dvrt_cell.sv =====
// one route entry of the shifting table chain
module dvrt_cell import dvrt_pkg::*; (
	input  logic   clk,
	input  logic   shift_en,
	input  logic   wr_en,
	input  route_t wr_entry,
	input  route_t nxt_entry,
	output route_t entry
);

	route_t entry_q;

	// a direct write wins over the shift from the right neighbor
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_entry;
		end else if (shift_en) begin
			entry_q <= nxt_entry;
		end
	end

	assign entry = entry_q;

endmodule

// ===== hdl/distance_vector_route_table_core.sv =====
// distance-vector route table engine: control and the chain of route cells
//
// usage
// - input items enter on start while busy is low; item.command picks forward,
//   vector entry update, tick, purge or emit vector. commands 5 to 7 are
//   accepted and dropped without a result
// - results leave on result with a one-cycle result_valid strobe; the
//   receiver cannot stall, so every strobe must be taken
// - configuration: wr_en, wr_index (0 router id, 1 age limit, 2 infinity
//   metric) and wr_data; write only while busy is low and no item is pending
// timing
// - tick answers in the cycle after it is taken and never raises busy
// - forward, update, purge and emit rotate the whole cell chain once: a scan
//   state that brings each cell to the head in turn, then a finish state; busy
//   stays high through both, so no new item is taken until the finish is done
// - emit streams its vector entries during the scan, at most one per cycle;
//   the last entry of the run comes out of the finish cycle
// reset
// - the table is empty, the time counter is zero, registers take their
//   defaults (router id 1, age limit 3, infinity metric 8)
module distance_vector_route_table_core import dvrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_item_t   item,
	output logic       result_valid,
	output out_item_t  result,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [15:0] wr_data
);

	// configuration
	logic [NODE_BITS-1:0] router_id_q;
	logic [15:0]          age_limit_q;
	logic [3:0]           infinity_q;

	// control state
	state_t               state_q, state_nxt;
	logic [CNT_W-1:0]     step_q;
	logic [CNT_W-1:0]     keep_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 found_q;
	logic                 changed_q;
	logic [NODE_BITS-1:0] found_nh_q;
	in_item_t             item_q;
	out_item_t            pend_q;
	out_item_t            res_q;
	logic                 res_valid_q;

	// cell chain
	route_t               cells [TABLE_DEPTH];
	route_t               head;
	route_t               mod_entry;
	route_t               wr_entry;
	logic [TABLE_DEPTH-1:0] wr_sel;
	logic [IDX_W-1:0]     wr_pos;

	logic                 scan_en, fin_en, accept, last_step;
	logic                 live, match, upd_hit, stale, drop, keep, emit_hit;
	logic                 is_upd, is_fwd, is_purge, is_emit, is_self;
	logic                 insert_ok;
	logic [3:0]           nm;
	logic [TIME_BITS-1:0] age;
	logic [CNT_W-1:0]     count_fin;
	out_item_t            fin_res;
	out_item_t            pend_init;
	out_item_t            tick_res;
	out_item_t            vec_res;

	assign accept = start && !busy;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (item.command == CMD_FORWARD || item.command == CMD_UPDATE ||
					item.command == CMD_PURGE || item.command == CMD_EMIT)) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_step) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state decodes
	always_comb begin
		busy    = 1'b1;
		scan_en = 1'b0;
		fin_en  = 1'b0;
		unique case (state_q)
			ST_IDLE: busy    = 1'b0;
			ST_SCAN: scan_en = 1'b1;
			ST_FIN:  fin_en  = 1'b1;
			default: busy    = 1'b1;
		endcase
	end

	assign last_step = (step_q == CNT_W'(TABLE_DEPTH - 1));

	// per-step look at the head of the chain
	assign head     = cells[0];
	assign is_upd   = (item_q.command == CMD_UPDATE);
	assign is_fwd   = (item_q.command == CMD_FORWARD);
	assign is_purge = (item_q.command == CMD_PURGE);
	assign is_emit  = (item_q.command == CMD_EMIT);
	assign is_self  = (item_q.dest_id == router_id_q);
	assign nm       = (item_q.metric == METRIC_MAX) ? METRIC_MAX : item_q.metric + 4'd1;

	assign live  = (step_q < count_q);
	assign match = live && !found_q && (head.dest == item_q.dest_id);
	assign upd_hit = is_upd && match && !is_self &&
		((head.metric > nm) || (head.next_hop == item_q.neighbor_id));
	assign age   = now_q - head.stamp;
	assign stale = (32'(age) > 32'(age_limit_q));
	assign drop  = is_purge && (head.dest != router_id_q) && stale;
	assign keep  = live && !drop;
	assign emit_hit = is_emit && live && (head.next_hop != item_q.neighbor_id);

	always_comb begin
		mod_entry = head;
		if (upd_hit) begin
			mod_entry.metric   = nm;
			mod_entry.next_hop = item_q.neighbor_id;
			mod_entry.stamp    = now_q;
		end
	end

	// kept entries land where the remaining shifts carry them to slot keep_q
	assign wr_pos = IDX_W'(keep_q + CNT_W'(TABLE_DEPTH - 1) - step_q);

	// finish: new route goes to the first free slot
	assign insert_ok = is_upd && !found_q && !is_self && (nm < infinity_q) &&
		(keep_q < CNT_W'(TABLE_DEPTH));
	assign count_fin = keep_q + CNT_W'(insert_ok);

	always_comb begin
		wr_entry.dest     = item_q.dest_id;
		wr_entry.next_hop = item_q.neighbor_id;
		wr_entry.metric   = nm;
		wr_entry.stamp    = now_q;
		wr_sel            = '0;
		if (scan_en) begin
			wr_entry = mod_entry;
			if (keep) begin
				wr_sel[wr_pos] = 1'b1;
			end
		end else if (fin_en && insert_ok) begin
			wr_sel[keep_q[IDX_W-1:0]] = 1'b1;
		end
	end

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		dvrt_cell u_cell (
			.clk       (clk),
			.shift_en  (scan_en),
			.wr_en     (wr_sel[k]),
			.wr_entry  (wr_entry),
			.nxt_entry (cells[(k + 1) % TABLE_DEPTH]),
			.entry     (cells[k])
		);
	end

	// result of the finish cycle
	always_comb begin
		fin_res               = '0;
		fin_res.table_entries = count_fin;
		fin_res.last          = 1'b1;
		if (is_fwd) begin
			fin_res.kind = KIND_FORWARD;
			if (is_self) begin
				fin_res.action   = ACT_LOCAL;
				fin_res.ttl_left = item_q.ttl;
			end else if (item_q.ttl <= 8'd1) begin
				fin_res.action = ACT_EXPIRED;
			end else if (found_q) begin
				fin_res.action   = ACT_FORWARDED;
				fin_res.next_hop = 8'(found_nh_q);
				fin_res.ttl_left = item_q.ttl - 8'd1;
			end else begin
				fin_res.action   = ACT_NO_ROUTE;
				fin_res.ttl_left = item_q.ttl - 8'd1;
			end
		end else if (is_upd) begin
			fin_res.kind = KIND_UPDATE;
			fin_res.last = item_q.end_of_vector;
			if (is_self) begin
				fin_res.action = ACT_IGNORED;
			end else if (found_q) begin
				fin_res.action = changed_q ? ACT_CHANGED : ACT_IGNORED;
			end else if (nm < infinity_q) begin
				fin_res.action = insert_ok ? ACT_ADDED : ACT_FULL;
			end else begin
				fin_res.action = ACT_IGNORED;
			end
		end else if (is_purge) begin
			fin_res.kind = KIND_PURGE;
		end else begin
			// emit: the held entry closes the run
			fin_res      = pend_q;
			fin_res.last = 1'b1;
		end
	end

	// self route that leads an emitted vector, tick answer, next held vector entry
	always_comb begin
		pend_init               = '0;
		pend_init.kind          = KIND_VECTOR;
		pend_init.out_dest      = 8'(router_id_q);
		pend_init.table_entries = count_q;
		tick_res                = '0;
		tick_res.kind           = KIND_TICK;
		tick_res.table_entries  = count_q;
		tick_res.last           = 1'b1;
		vec_res                 = pend_q;
		vec_res.out_dest        = 8'(head.dest);
		vec_res.out_metric      = head.metric;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			router_id_q <= NODE_BITS'(1);
			age_limit_q <= 16'd3;
			infinity_q  <= 4'd8;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROUTER_ID: router_id_q <= wr_data[NODE_BITS-1:0];
				REG_AGE_LIMIT: age_limit_q <= wr_data;
				REG_INFINITY:  infinity_q  <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			keep_q      <= '0;
			count_q     <= '0;
			now_q       <= '0;
			found_q     <= 1'b0;
			changed_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			res_valid_q <= 1'b0;
			if (accept) begin
				step_q    <= '0;
				keep_q    <= '0;
				found_q   <= 1'b0;
				changed_q <= 1'b0;
				if (item.command == CMD_TICK) begin
					now_q       <= now_q + TIME_BITS'(1);
					res_valid_q <= 1'b1;
				end
			end
			if (scan_en) begin
				step_q <= step_q + CNT_W'(1);
				if (keep) begin
					keep_q <= keep_q + CNT_W'(1);
				end
				if (match) begin
					found_q   <= 1'b1;
					changed_q <= upd_hit;
				end
				if (emit_hit) begin
					res_valid_q <= 1'b1;
				end
			end
			if (fin_en) begin
				count_q     <= count_fin;
				res_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			pend_q <= pend_init;
			if (item.command == CMD_TICK) begin
				res_q <= tick_res;
			end
		end
		if (scan_en && match) begin
			found_nh_q <= head.next_hop;
		end
		if (scan_en && emit_hit) begin
			res_q  <= pend_q;
			pend_q <= vec_res;
		end
		if (fin_en) begin
			res_q <= fin_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
